FILE: hdl/bmp_rle_scanline_decoder_macros.svh
`ifndef BMP_RLE_SCANLINE_DECODER_MACROS_SVH
`define BMP_RLE_SCANLINE_DECODER_MACROS_SVH

// check cons in the same cycle as ante
`define BMP_RLE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmp_rle: check failed");

// check cons in the cycle after ante
`define BMP_RLE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmp_rle: check failed");

`endif

FILE: hdl/bmp_rle_pkg.sv
package bmp_rle_pkg;

  localparam int PIXELS_PER_RESULT_DEF = 8;
  localparam int MAX_PIXELS = 8;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_METHOD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_SIZE = 4'd1;

  localparam logic [1:0] METHOD_RLE8 = 2'd1;
  localparam logic [1:0] METHOD_RLE4 = 2'd2;

  localparam logic [1:0] METHOD_RESET = METHOD_RLE8;
  localparam logic [15:0] BUFFER_SIZE_RESET = 16'hFFFF;
  localparam logic [15:0] BUFFER_RESERVE = 16'd2;

  typedef enum logic [2:0] {
    ST_RUN = 3'd0,
    ST_EOL = 3'd1,
    ST_EOB = 3'd2,
    ST_BADMETHOD = 3'd3,
    ST_DELTA = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_TRUNC = 3'd6
  } status_t;

  localparam logic [7:0] ESC_EOL = 8'd0;
  localparam logic [7:0] ESC_EOB = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic [1:0] method;
    logic [15:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic [15:0] a;
    logic [7:0] b;
    logic [15:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] sum;
    logic over;
  } alu_rsp_t;

endpackage

FILE: hdl/bmp_rle_if.sv
interface bmp_rle_byte_if import bmp_rle_pkg::*; ();
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic start_line;

  modport source(output valid, data_byte, start_line, input ready);
  modport sink(input valid, data_byte, start_line, output ready);
endinterface

interface bmp_rle_result_if import bmp_rle_pkg::*; ();
  logic valid;
  logic ready;
  logic [63:0] pixels;
  logic [3:0] pixel_count;
  logic [15:0] first_index;
  logic [2:0] status;
  logic last;

  modport source(output valid, pixels, pixel_count, first_index, status, last, input ready);
  modport sink(input valid, pixels, pixel_count, first_index, status, last, output ready);
endinterface

interface bmp_rle_cfg_if import bmp_rle_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/bmp_rle_cfg_regs.sv
module bmp_rle_cfg_regs import bmp_rle_pkg::*; (
  input logic clk,
  input logic rst,
  bmp_rle_cfg_if.sink cfg,
  output cfg_t cfg_s
);

  logic [1:0] method;
  logic [15:0] capacity;

  assign cfg.ready = 1'b1;
  assign cfg_s.method = method;
  assign cfg_s.capacity = capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      method <= METHOD_RESET;
      capacity <= BUFFER_SIZE_RESET - BUFFER_RESERVE;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_METHOD: begin
          method <= cfg.data[1:0];
        end
        REG_BUFFER_SIZE: begin
          capacity <= (cfg.data >= BUFFER_RESERVE) ? cfg.data - BUFFER_RESERVE : 16'd0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/bmp_rle_alu.sv
module bmp_rle_alu import bmp_rle_pkg::*; (
  input alu_req_t req,
  output alu_rsp_t rsp
);

  logic [16:0] sum;

  assign sum = {1'b0, req.a} + {9'd0, req.b};
  assign rsp.sum = sum[15:0];
  assign rsp.over = sum > {1'b0, req.limit};

endmodule

FILE: hdl/bmp_rle_seq.sv
`include "bmp_rle_scanline_decoder_macros.svh"

module bmp_rle_seq import bmp_rle_pkg::*; #(
  parameter int PIXELS_PER_RESULT = PIXELS_PER_RESULT_DEF
) (
  input logic clk,
  input logic rst,
  bmp_rle_byte_if.sink byte_stream,
  bmp_rle_result_if.source result,
  input cfg_t cfg_s,
  output alu_req_t alu_req,
  input alu_rsp_t alu_rsp
);

  localparam int NW = $clog2(PIXELS_PER_RESULT + 1);
  localparam logic [7:0] GROUP_MAX = 8'(PIXELS_PER_RESULT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_GROUP,
    S_ADVANCE,
    S_STATUS
  } state_t;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_VALUE,
    PH_LITERAL,
    PH_PAD
  } phase_t;

  state_t state;
  phase_t parse_phase;
  logic [7:0] held_count;
  logic [7:0] literal_left;
  logic pad_pending;
  logic [15:0] pixel_index;
  logic line_finished;

  logic [7:0] data_reg;
  status_t st_code;
  logic [7:0] run_left;
  logic [7:0] run_val;
  logic run_rle4;
  logic run_parity;
  logic [NW-1:0] adv_n;

  logic rv;
  logic [63:0] r_pixels;
  logic [3:0] r_count;
  logic [15:0] r_first;
  status_t r_status;
  logic r_last;

  logic slot_free;
  logic rle4;
  logic method_ok;
  logic [NW-1:0] grp_n;
  logic [63:0] grp_pix;
  logic [1:0] lit_n;
  logic [7:0] lit_rest;
  logic lit_pad;

  assign byte_stream.ready = (state == S_IDLE);
  assign slot_free = !rv || result.ready;
  assign rle4 = (cfg_s.method == METHOD_RLE4);
  assign method_ok = (cfg_s.method == METHOD_RLE8) || (cfg_s.method == METHOD_RLE4);

  assign result.valid = rv;
  assign result.pixels = r_pixels;
  assign result.pixel_count = r_count;
  assign result.first_index = r_first;
  assign result.status = r_status;
  assign result.last = r_last;

  always_comb begin
    alu_req.a = pixel_index;
    alu_req.limit = cfg_s.capacity;
    if (state == S_ADVANCE) begin
      alu_req.b = 8'(adv_n);
    end else begin
      alu_req.b = (held_count == 8'd0) ? data_reg : held_count;
    end
  end

  always_comb begin
    grp_n = (run_left > GROUP_MAX) ? NW'(PIXELS_PER_RESULT) : NW'(run_left);
    grp_pix = '0;
    for (int j = 0; j < MAX_PIXELS; j++) begin
      if (j < PIXELS_PER_RESULT && j < int'(grp_n)) begin
        if (!run_rle4) begin
          grp_pix[8*j +: 8] = run_val;
        end else if (run_parity ^ j[0]) begin
          grp_pix[8*j +: 8] = {4'd0, run_val[3:0]};
        end else begin
          grp_pix[8*j +: 8] = {4'd0, run_val[7:4]};
        end
      end
    end
  end

  always_comb begin
    if (literal_left == 8'd0) begin
      lit_n = 2'd0;
    end else if (rle4 && literal_left >= 8'd2) begin
      lit_n = 2'd2;
    end else begin
      lit_n = 2'd1;
    end
    lit_rest = literal_left - {6'd0, lit_n};
    lit_pad = rle4 ? ((data_reg[1:0] == 2'd1) || (data_reg[1:0] == 2'd2)) : data_reg[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      parse_phase <= PH_COUNT;
      held_count <= '0;
      literal_left <= '0;
      pad_pending <= 1'b0;
      pixel_index <= '0;
      line_finished <= 1'b0;
      rv <= 1'b0;
    end else begin
      if (rv && result.ready) begin
        rv <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (byte_stream.valid) begin
            data_reg <= byte_stream.data_byte;
            if (byte_stream.start_line) begin
              parse_phase <= PH_COUNT;
              held_count <= '0;
              literal_left <= '0;
              pad_pending <= 1'b0;
              pixel_index <= '0;
              line_finished <= 1'b0;
            end
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          st_code <= ST_RUN;
          state <= S_STATUS;
          run_val <= data_reg;
          run_rle4 <= rle4;
          run_parity <= 1'b0;
          if (line_finished) begin
            st_code <= ST_RUN;
          end else if (!method_ok) begin
            st_code <= ST_BADMETHOD;
            line_finished <= 1'b1;
            parse_phase <= PH_COUNT;
            literal_left <= '0;
            pad_pending <= 1'b0;
          end else begin
            unique case (parse_phase)
              PH_COUNT: begin
                held_count <= data_reg;
                parse_phase <= PH_VALUE;
              end
              PH_VALUE: begin
                parse_phase <= PH_COUNT;
                if (held_count == 8'd0 && (data_reg == ESC_EOL || data_reg == ESC_EOB ||
                                           data_reg == ESC_DELTA)) begin
                  st_code <= (data_reg == ESC_EOL) ? ST_EOL :
                             (data_reg == ESC_EOB) ? ST_EOB : ST_DELTA;
                  line_finished <= 1'b1;
                  literal_left <= '0;
                  pad_pending <= 1'b0;
                end else begin
                  state <= S_CHECK;
                end
              end
              PH_LITERAL: begin
                literal_left <= lit_rest;
                if (lit_rest == 8'd0) begin
                  parse_phase <= pad_pending ? PH_PAD : PH_COUNT;
                end
                if (lit_n != 2'd0) begin
                  run_left <= {6'd0, lit_n};
                  state <= S_GROUP;
                end
              end
              PH_PAD: begin
                pad_pending <= 1'b0;
                parse_phase <= PH_COUNT;
              end
              default: begin
              end
            endcase
          end
        end
        S_CHECK: begin
          if (alu_rsp.over) begin
            st_code <= (held_count == 8'd0 || rle4) ? ST_OVERFLOW : ST_TRUNC;
            line_finished <= 1'b1;
            parse_phase <= PH_COUNT;
            literal_left <= '0;
            pad_pending <= 1'b0;
            state <= S_STATUS;
          end else if (held_count == 8'd0) begin
            literal_left <= data_reg;
            pad_pending <= lit_pad;
            parse_phase <= PH_LITERAL;
            st_code <= ST_RUN;
            state <= S_STATUS;
          end else begin
            run_left <= held_count;
            state <= S_GROUP;
          end
        end
        S_GROUP: begin
          if (slot_free) begin
            rv <= 1'b1;
            r_pixels <= grp_pix;
            r_count <= 4'(grp_n);
            r_first <= pixel_index;
            r_status <= ST_RUN;
            r_last <= (run_left == 8'(grp_n));
            adv_n <= grp_n;
            run_left <= run_left - 8'(grp_n);
            run_parity <= run_parity ^ grp_n[0];
            state <= S_ADVANCE;
          end
        end
        S_ADVANCE: begin
          pixel_index <= alu_rsp.sum;
          state <= (run_left == 8'd0) ? S_IDLE : S_GROUP;
        end
        S_STATUS: begin
          if (slot_free) begin
            rv <= 1'b1;
            r_pixels <= '0;
            r_count <= 4'd0;
            r_first <= pixel_index;
            r_status <= st_code;
            r_last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BMP_RLE_ASSERT_NXT(a_busy_after_accept, clk, rst,
    byte_stream.valid && byte_stream.ready, !byte_stream.ready)
  `BMP_RLE_ASSERT_IMP(a_pixels_only_running, clk, rst,
    result.valid && result.pixel_count != 4'd0, result.status == ST_RUN)
  `BMP_RLE_ASSERT_IMP(a_group_bound, clk, rst,
    result.valid, result.pixel_count <= 4'(PIXELS_PER_RESULT))
  `BMP_RLE_ASSERT_IMP(a_more_groups_pending, clk, rst,
    result.valid && result.ready && !result.last, state != S_IDLE)

endmodule

FILE: hdl/bmp_rle_scanline_decoder.sv
// channel      role    moves
// byte_stream  sink    one compressed byte and its start_line flag
// result       source  up to PIXELS_PER_RESULT pixels with index, status, last
// cfg          sink    register write: index 0 method, index 1 buffer_size
//
// A byte that makes no pixels passes decode and status; one that opens a literal or
// fails the capacity check passes decode, check and status. An encoded run passes
// decode and check, then group and advance per pixel group, a literal byte decode,
// group and advance. The shared adder and compare unit serves the capacity check
// and every pixel index advance. Reset is synchronous; cfg is always ready. A
// stalled result holds the sequencer, byte_stream.ready is high only between bytes.
module bmp_rle_scanline_decoder import bmp_rle_pkg::*; #(
  parameter int PIXELS_PER_RESULT = PIXELS_PER_RESULT_DEF
) (
  input logic clk,
  input logic rst,
  bmp_rle_byte_if.sink byte_stream,
  bmp_rle_result_if.source result,
  bmp_rle_cfg_if.sink cfg
);

  cfg_t cfg_s;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  bmp_rle_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cfg_s(cfg_s)
  );

  bmp_rle_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  bmp_rle_seq #(
    .PIXELS_PER_RESULT(PIXELS_PER_RESULT)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .byte_stream(byte_stream),
    .result(result),
    .cfg_s(cfg_s),
    .alu_req(alu_req),
    .alu_rsp(alu_rsp)
  );

endmodule
